// File: rtl/bbt_pkg.sv
// Package for the Bollinger band tracker: field widths and shared constants.
// Used by bbt_divsqrt and bollinger_band_tracker; depends on nothing.
`timescale 1ns / 1ps
package bbt_pkg;
	localparam int SampleW = 24;
	localparam int FactorW = 16;
	localparam int LenRegW = 7;
	localparam int LenW    = 11;
	localparam int SumW    = 42;
	localparam int SqW     = 64;
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} unit_cmd_t;
endpackage

// File: rtl/bollinger_band_tracker.sv
// Bollinger band tracker top level: window memory, running sums, band math.
// Depends on bbt_pkg and bbt_divsqrt.
`timescale 1ns / 1ps
// A valid sample that leaves the window full has its result registered after
// these steps: read the leaving sample, update the running sums, start the
// mean division, the 64-step mean division, form the variance numerator and
// start its division, the 64-step variance division, the 32-step square root
// and the bands; the divisions and the square root run in the shared
// bbt_divsqrt unit.
// Items before the window fills give their result once the running sums are
// updated, invalid samples at the transfer itself. One item is worked at a
// time; a finished result sits in an output register and the next item is
// taken in the cycle that result leaves. Writing window_length restarts the
// window.
module bollinger_band_tracker import bbt_pkg::*; #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SampleW-1:0] sample,
	input  logic                      sample_valid,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SampleW-1:0] band_mid,
	output logic signed [SampleW-1:0] band_hi,
	output logic signed [SampleW-1:0] band_lo,
	output logic                      bands_valid
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int BandW = SampleW + FactorW - 6;
	localparam logic [3:0] StIdle = 4'd0, StRead = 4'd1, StUpd = 4'd2,
		StStart = 4'd3, StMean = 4'd4, StNum = 4'd5, StVar = 4'd6,
		StSqrt = 4'd7, StOut = 4'd8;
	localparam logic [0:0] RegLen = 1'd0, RegFac = 1'd1;
	localparam logic signed [BandW-1:0] SatHi = BandW'(8388607);
	localparam logic signed [BandW-1:0] SatLo = BandW'(-8388608);

	logic [LenRegW-1:0] wlen_q;
	logic [FactorW-1:0] fac_q;
	logic [3:0] st_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] fill_q;
	logic signed [SumW-1:0] sum_q;
	logic [SqW-1:0] sq_q;
	logic signed [SampleW-1:0] x_q, old_q, mean_q;
	logic signed [SampleW-1:0] mem [WINDOW_DEPTH];
	logic [SampleW-1:0] dev_q;
	logic [2*SampleW-1:0] mm_q;
	logic signed [LenW:0] rm_q;
	logic full, ovalid_q;
	logic [CW-1:0] len;
	logic cfg_wr, restart, finish;
	unit_cmd_t cmd;
	logic [SqW-1:0] opnd, ures;
	logic [LenW-1:0] urem;
	logic udone;
	logic [SumW-1:0] abs_sum;
	logic signed [2*SampleW-1:0] x_sq, old_sq;
	logic [2*SampleW-1:0] mm;
	logic [2*SampleW+CW-1:0] lmm;
	logic signed [SampleW+LenW:0] mr;
	logic [SqW-1:0] num;
	logic [SampleW+FactorW-1:0] off;
	logic signed [BandW-1:0] offs, up, lo;

	always_comb begin
		if (wlen_q == '0) len = CW'(1);
		else if ({{(32-LenRegW){1'b0}}, wlen_q} > 32'(WINDOW_DEPTH)) len = CW'(WINDOW_DEPTH);
		else len = CW'(wlen_q);
	end

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign restart = cfg_wr && (paddr[2] == RegLen);
	always_comb begin
		unique case (paddr[2])
			RegLen: prdata = {{(32-LenRegW){1'b0}}, wlen_q};
			RegFac: prdata = {{(32-FactorW){1'b0}}, fac_q};
			default: prdata = '0;
		endcase
	end

	assign full = (fill_q >= len);
	assign in_stall = (st_q != StIdle) || (ovalid_q && out_stall) || restart;
	assign out_valid = ovalid_q;
	assign finish = (st_q == StIdle && in_valid && !in_stall && !sample_valid) ||
		(st_q == StStart && !full) || (st_q == StOut);

	assign abs_sum = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
	assign x_sq = x_q * x_q;
	assign old_sq = old_q * old_q;
	// The sign of the mean does not matter for its square.
	assign mm = ures[SampleW-1:0] * ures[SampleW-1:0];
	// With S = L*m + r, the sum of squared deviations is Q - L*m^2 - 2*m*r.
	assign lmm = len * mm_q;
	assign mr = mean_q * rm_q;
	assign num = sq_q - SqW'(lmm) - (SqW'(mr) << 1);
	assign off = {{SampleW{1'b0}}, fac_q} * {{FactorW{1'b0}}, dev_q};
	assign offs = signed'({2'b00, off[SampleW+FactorW-1:8]});
	assign up = BandW'(mean_q) + offs;
	assign lo = BandW'(mean_q) - offs;

	always_comb begin
		cmd = '0;
		opnd = num;
		if (st_q == StStart && full) begin
			cmd.start = 1'b1;
			opnd = SqW'(abs_sum);
		end else if (st_q == StNum) begin
			cmd.start = 1'b1;
		end else if (st_q == StVar && udone) begin
			cmd.start = 1'b1;
			cmd.is_sqrt = 1'b1;
			opnd = ures;
		end
	end

	bbt_divsqrt u_unit (.clk, .arst_n, .cmd, .operand(opnd),
		.divisor(LenW'(len)), .done(udone), .result(ures), .remainder(urem));

	always_ff @(posedge clk) begin
		if (st_q == StUpd) mem[slot_q] <= x_q;
		old_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= 7'd20; fac_q <= 16'd512; st_q <= StIdle;
			slot_q <= '0; fill_q <= '0; sum_q <= '0; sq_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (finish) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			if (cfg_wr && paddr[2] == RegFac) fac_q <= pwdata[FactorW-1:0];
			if (restart) begin
				wlen_q <= pwdata[LenRegW-1:0];
				slot_q <= '0; fill_q <= '0; sum_q <= '0; sq_q <= '0;
			end else begin
				unique case (st_q)
					StIdle: if (in_valid && !in_stall) begin
						x_q <= sample;
						if (!sample_valid) begin
							band_mid <= '0; band_hi <= '0; band_lo <= '0;
							bands_valid <= 1'b0;
						end else begin
							if ({{(32-AW){1'b0}}, slot_q} >= 32'(len)) slot_q <= '0;
							st_q <= StRead;
						end
					end
					StRead: st_q <= StUpd;
					StUpd: begin
						if (fill_q >= len) begin
							sum_q <= sum_q - SumW'(old_q) + SumW'(x_q);
							sq_q <= sq_q - SqW'(old_sq) + SqW'(x_sq);
							fill_q <= len;
						end else begin
							sum_q <= sum_q + SumW'(x_q);
							sq_q <= sq_q + SqW'(x_sq);
							fill_q <= fill_q + CW'(1);
						end
						slot_q <= (CW'(slot_q) + CW'(1) >= len) ? '0 : slot_q + AW'(1);
						st_q <= StStart;
					end
					StStart: if (!full) begin
						band_mid <= '0; band_hi <= '0; band_lo <= '0;
						bands_valid <= 1'b0; st_q <= StIdle;
					end else begin
						st_q <= StMean;
					end
					StMean: if (udone) begin
						mean_q <= sum_q[SumW-1] ? -SampleW'(ures) : SampleW'(ures);
						mm_q <= mm;
						rm_q <= sum_q[SumW-1] ? -signed'({1'b0, urem}) : signed'({1'b0, urem});
						st_q <= StNum;
					end
					StNum: st_q <= StVar;
					StVar: if (udone) st_q <= StSqrt;
					StSqrt: if (udone) begin
						dev_q <= ures[SampleW-1:0];
						st_q <= StOut;
					end
					StOut: begin
						band_mid <= mean_q;
						band_hi <= (up > SatHi) ? SampleW'(SatHi) : SampleW'(up);
						band_lo <= (lo < SatLo) ? SampleW'(SatLo) : SampleW'(lo);
						bands_valid <= 1'b1; st_q <= StIdle;
					end
					default: st_q <= StIdle;
				endcase
			end
		end
	end
endmodule

// File: rtl/bbt_divsqrt.sv
// Shared multi-cycle unit: restoring unsigned division and floor square root,
// one result bit per cycle. Depends on bbt_pkg.
`timescale 1ns / 1ps
module bbt_divsqrt import bbt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  unit_cmd_t       cmd,
	input  logic [SqW-1:0]  operand,
	input  logic [LenW-1:0] divisor,
	output logic            done,
	output logic [SqW-1:0]  result,
	output logic [LenW-1:0] remainder
);
	logic [SqW-1:0] rem_q;
	logic [SqW-1:0] num_q;
	logic [SqW-1:0] root_q;
	logic [6:0]     cnt_q;
	logic           busy_q;
	logic           sqrt_q;
	logic [SqW+1:0] rem_next;
	logic [SqW+1:0] trial;

	always_comb begin
		if (sqrt_q) begin
			rem_next = {rem_q, num_q[SqW-1 -: 2]};
			trial = {root_q, 2'b01};
		end else begin
			rem_next = {2'b00, rem_q[SqW-2:0], num_q[SqW-1]};
			trial = {{(SqW+2-LenW){1'b0}}, divisor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.is_sqrt ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			num_q <= operand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (sqrt_q) num_q <= {num_q[SqW-3:0], 2'b00};
			else num_q <= {num_q[SqW-2:0], 1'b0};
			if (rem_next >= trial) begin
				rem_q <= SqW'(rem_next - trial);
				root_q <= {root_q[SqW-2:0], 1'b1};
			end else begin
				rem_q <= SqW'(rem_next);
				root_q <= {root_q[SqW-2:0], 1'b0};
			end
		end
	end

	assign result = root_q;
	assign remainder = rem_q[LenW-1:0];
endmodule
